>>> src/xfsd_pkg.sv
// Shared constants and types of the XOR float stream decoder.
package xfsd_pkg;

	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned VALUE_W    = 64;
	localparam int unsigned FIRST_BITS = 64;
	localparam int unsigned HDR_BITS   = 11;
	localparam int unsigned WIDTH_BITS = 6;
	localparam int unsigned LEAD_BITS  = 5;
	localparam int unsigned COUNT_W    = 7;
	localparam int unsigned TRAIL_W    = 6;

	typedef struct packed {
		logic              valid;
		logic [BYTE_W-1:0] data;
	} head_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value_bits;
		logic               header_error;
	} result_t;

endpackage

>>> src/xfsd_if.sv
// Stream channels of the decoder: byte input and decoded value output.
interface xfsd_byte_if;
	logic                         valid;
	logic                         ready;
	logic [xfsd_pkg::BYTE_W-1:0]  stream_byte;

	modport source(output valid, output stream_byte, input ready);
	modport sink(input valid, input stream_byte, output ready);
endinterface

interface xfsd_value_if;
	logic                         valid;
	logic                         ready;
	logic [xfsd_pkg::VALUE_W-1:0] value_bits;
	logic                         header_error;
	logic                         last_of_run;

	modport source(output valid, output value_bits, output header_error,
		output last_of_run, input ready);
	modport sink(input valid, input value_bits, input header_error,
		input last_of_run, output ready);
endinterface

>>> src/xor_float_stream_decoder.sv
// Top level of the XOR float stream decoder: byte queue and bit-serial back end.
//
// Rebuilds 64-bit double bit patterns from an XOR-compressed bit stream fed one
// byte per beat, bit 7 first. The back end parses one stream bit per cycle
// through the bit-serial parser, and a byte that completes several values
// yields one result beat per cycle, both while the output side keeps up: the
// parser stalls while a value is pending and the output register is held. A
// queue of QUEUE_DEPTH bytes takes new beats while the parser works, and a
// pending result register plus an output register let the parser continue
// while a finished value waits to be taken. The last value a byte completes
// carries last_of_run; with the output side ready it enters the output register
// as the byte's final bit is parsed, or, when that final bit completes the
// value, goes through the pending register first and then the output register.
module xor_float_stream_decoder #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	xfsd_byte_if.sink    bytes,
	xfsd_value_if.source values
);

	xfsd_pkg::head_t q_head;
	logic            q_pop;

	xfsd_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.bytes (bytes),
		.pop   (q_pop),
		.head  (q_head)
	);

	xfsd_back u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.head  (q_head),
		.pop   (q_pop),
		.values(values)
	);

	a_pop_needs_byte: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_head.valid)
		else $error("byte taken from an empty queue");

	a_full_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		!bytes.ready |-> q_head.valid)
		else $error("queue refuses beats while empty");

	a_pop_frees_room: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && !(bytes.valid && bytes.ready)) |=> bytes.ready)
		else $error("queue still full after a byte left");

endmodule

>>> src/xfsd_queue.sv
// Front end: accepts stream bytes into a short queue ahead of the bit parser.
module xfsd_queue #(
	parameter int unsigned DEPTH = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	xfsd_byte_if.sink       bytes,
	input  logic            pop,
	output xfsd_pkg::head_t head
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [xfsd_pkg::BYTE_W-1:0] mem_q [DEPTH];
	logic [PW-1:0]               wr_ptr_q;
	logic [PW-1:0]               rd_ptr_q;
	logic [CW-1:0]               cnt_q;
	logic                        push;

	assign bytes.ready = (cnt_q != CW'(DEPTH));
	assign push        = bytes.valid && bytes.ready;
	assign head.valid  = (cnt_q != '0);
	assign head.data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + CW'(push) - CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= bytes.stream_byte;
		end
	end

endmodule

>>> src/xfsd_back.sv
// Back end: bit-serial parser, XOR reconstruction and result output stage.
module xfsd_back (
	input  logic            clk,
	input  logic            arst_n,
	input  xfsd_pkg::head_t head,
	output logic            pop,
	xfsd_value_if.source    values
);

	localparam int unsigned VW = xfsd_pkg::VALUE_W;
	localparam int unsigned CW = xfsd_pkg::COUNT_W;
	localparam int unsigned TW = xfsd_pkg::TRAIL_W;
	localparam int unsigned WB = xfsd_pkg::WIDTH_BITS;
	localparam int unsigned LB = xfsd_pkg::LEAD_BITS;

	typedef enum logic [2:0] {
		PH_FIRST,
		PH_CTRL1,
		PH_CTRL2,
		PH_HEADER,
		PH_DATA
	} phase_t;

	phase_t                      phase_q, phase_d;
	logic [VW-1:0]               shift_q, shift_d;
	logic [CW-1:0]               count_q, count_d;
	logic [CW-1:0]               width_q, width_d;
	logic [TW-1:0]               trail_q, trail_d;
	logic                        bad_q, bad_d;
	logic [VW-1:0]               prev_q, prev_d;

	logic [xfsd_pkg::BYTE_W-1:0] byte_q;
	logic [2:0]                  bit_idx_q;
	logic                        byte_valid_q;

	xfsd_pkg::result_t           pend_q;
	logic                        pend_valid_q;
	logic                        pend_last_q;
	xfsd_pkg::result_t           out_q;
	logic                        out_last_q;
	logic                        out_valid_q;

	logic                        bit_now;
	logic                        last_bit;
	logic                        out_free;
	logic                        step;
	logic                        push;
	logic                        push_last;
	logic                        res_hit;
	logic                        res_err;
	logic [VW-1:0]               sh;
	logic [CW-1:0]               cnt_inc;
	logic [WB-1:0]               hw;
	logic [LB-1:0]               hlead;
	logic [CW-1:0]               hwidth;
	logic [CW-1:0]               hsum;
	logic                        hbad;

	assign bit_now   = byte_q[bit_idx_q];
	assign last_bit  = (bit_idx_q == '0);
	assign out_free  = !out_valid_q || values.ready;
	assign step      = byte_valid_q && (out_free || !pend_valid_q);
	assign push      = out_free && pend_valid_q
		&& (pend_last_q || (step && (res_hit || last_bit)));
	assign push_last = pend_last_q || (step && last_bit && !res_hit);
	assign pop       = head.valid && (!byte_valid_q || (step && last_bit));

	assign values.valid        = out_valid_q;
	assign values.value_bits   = out_q.value_bits;
	assign values.header_error = out_q.header_error;
	assign values.last_of_run  = out_last_q;

	always_comb begin
		phase_d = phase_q;
		shift_d = shift_q;
		count_d = count_q;
		width_d = width_q;
		trail_d = trail_q;
		bad_d   = bad_q;
		prev_d  = prev_q;
		res_hit = 1'b0;
		res_err = 1'b0;
		sh      = {shift_q[VW-2:0], bit_now};
		cnt_inc = count_q + 1'b1;
		hw      = sh[WB-1:0];
		hlead   = sh[WB+LB-1:WB];
		hwidth  = (hw == '0) ? CW'(VW) : CW'(hw);
		hsum    = CW'(hlead) + hwidth;
		hbad    = (hsum > CW'(VW));
		case (phase_q)
			PH_FIRST: begin
				shift_d = sh;
				count_d = cnt_inc;
				if (cnt_inc >= CW'(xfsd_pkg::FIRST_BITS)) begin
					prev_d  = sh;
					shift_d = '0;
					count_d = '0;
					phase_d = PH_CTRL1;
					res_hit = 1'b1;
				end
			end
			PH_CTRL1: begin
				if (!bit_now) begin
					res_hit = 1'b1;
				end else begin
					phase_d = PH_CTRL2;
				end
			end
			PH_CTRL2: begin
				shift_d = '0;
				count_d = '0;
				if (bit_now) begin
					phase_d = PH_HEADER;
				end else if (width_q == '0) begin
					phase_d = PH_CTRL1;
					res_hit = 1'b1;
				end else begin
					phase_d = PH_DATA;
				end
			end
			PH_HEADER: begin
				shift_d = sh;
				count_d = cnt_inc;
				if (cnt_inc >= CW'(xfsd_pkg::HDR_BITS)) begin
					width_d = hwidth;
					bad_d   = hbad;
					trail_d = hbad ? '0 : TW'(CW'(VW) - hsum);
					shift_d = '0;
					count_d = '0;
					phase_d = PH_DATA;
				end
			end
			PH_DATA: begin
				shift_d = sh;
				count_d = cnt_inc;
				if (cnt_inc >= width_q) begin
					shift_d = '0;
					count_d = '0;
					phase_d = PH_CTRL1;
					res_hit = 1'b1;
					res_err = bad_q;
					if (!bad_q) begin
						prev_d = prev_q ^ (sh << trail_q);
					end
				end
			end
			default: begin
				phase_d = PH_FIRST;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_FIRST;
			shift_q      <= '0;
			count_q      <= '0;
			width_q      <= '0;
			trail_q      <= '0;
			bad_q        <= 1'b0;
			prev_q       <= '0;
			byte_q       <= '0;
			bit_idx_q    <= '0;
			byte_valid_q <= 1'b0;
			pend_q       <= '0;
			pend_valid_q <= 1'b0;
			pend_last_q  <= 1'b0;
			out_q        <= '0;
			out_last_q   <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (step) begin
				phase_q <= phase_d;
				shift_q <= shift_d;
				count_q <= count_d;
				width_q <= width_d;
				trail_q <= trail_d;
				bad_q   <= bad_d;
				prev_q  <= prev_d;
			end
			if (pop) begin
				bit_idx_q <= 3'd7;
			end else if (step) begin
				bit_idx_q <= bit_idx_q - 1'b1;
			end
			if (pop) begin
				byte_q       <= head.data;
				byte_valid_q <= 1'b1;
			end else if (step && last_bit) begin
				byte_valid_q <= 1'b0;
			end
			if (step && res_hit) begin
				pend_q.value_bits   <= prev_d;
				pend_q.header_error <= res_err;
				pend_valid_q        <= 1'b1;
				pend_last_q         <= last_bit;
			end else if (push) begin
				pend_valid_q <= 1'b0;
				pend_last_q  <= 1'b0;
			end
			if (push) begin
				out_q       <= pend_q;
				out_last_q  <= push_last;
				out_valid_q <= 1'b1;
			end else if (values.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
